>>> rtl/core/sensor_tag_advert_decoder_top_defines.svh
// Assertion helpers for the sensor tag decoder
`ifndef SENSOR_TAG_ADVERT_DECODER_TOP_DEFINES_SVH
`define SENSOR_TAG_ADVERT_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define STAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stad implication check failed");
`define STAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stad next-cycle check failed");
`else
`define STAD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STAD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/stad_pkg.sv
package stad_pkg;

    localparam int STORE_DEPTH = 26;
    localparam int CNT_W       = 5;
    localparam int DATA_W      = 192;

    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [CNT_W-1:0] FMT3_LEN  = 5'd16;
    localparam logic [CNT_W-1:0] FMT5_LEN  = 5'd26;
    localparam logic [CNT_W-1:0] STORE_LIM = 5'd26;

    localparam logic [15:0] COMPANY_ID_RESET = 16'h9904;
    localparam logic [7:0]  FMT3_CODE        = 8'd3;
    localparam logic [7:0]  FMT5_CODE        = 8'd5;
    localparam logic [16:0] PRESSURE_OFFSET  = 17'd50000;
    localparam logic [15:0] BATT_OFFSET      = 16'd1600;
    localparam logic [6:0]  TX_OFFSET        = 7'd40;
    localparam logic [15:0] FMT3_SCALE       = 16'd200;

    typedef enum logic [2:0] {
        ST_FMT3_OK    = 3'd0,
        ST_FMT5_OK    = 3'd1,
        ST_TOO_SHORT  = 3'd2,
        ST_WRONG_ID   = 3'd3,
        ST_WRONG_LEN  = 3'd4,
        ST_UNKNOWN_FM = 3'd5
    } status_t;

    typedef struct packed {
        logic [47:0] mac_address;
        logic [15:0] sequence_number;
        logic [7:0]  movement_count;
        logic [6:0]  tx_power_dbm;
        logic [15:0] battery_mv;
        logic [15:0] accel_z;
        logic [15:0] accel_y;
        logic [15:0] accel_x;
        logic [16:0] pressure;
        logic [15:0] humidity;
        logic [15:0] temperature;
    } meas_t;

endpackage

>>> rtl/core/sensor_tag_advert_decoder_top.sv
// Sensor tag manufacturer-data decoder (formats 3 and 5).
// Throughput: one byte per cycle while s_tready is high; bytes are stored in a
//   26-entry register file. After the last byte is accepted, pend_reg marks a decode
//   as pending, and the decode result is loaded into the output register once it is free.
//   A stalled output holds back tready only for the byte following a pending decode.
// Reset: aresetn synchronous, active low; clears count and valid flags, loads default ID.
`include "sensor_tag_advert_decoder_top_defines.svh"

module sensor_tag_advert_decoder_top
    import stad_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] packet_byte
    input  logic              s_tlast,   // last_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    // [15:0] temperature, [31:16] humidity, [48:32] pressure, [64:49] accel_x,
    // [80:65] accel_y, [96:81] accel_z, [112:97] battery_mv, [119:113] tx_power_dbm,
    // [127:120] movement_count, [143:128] sequence_number, [191:144] mac_address
    output logic [DATA_W-1:0] m_tdata,
    output logic [2:0]        m_tuser    // [2:0] status
);

    logic [7:0]       store_reg [STORE_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] len_reg;
    logic             pend_reg, pend_next;
    logic [15:0]      company_id_reg;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    meas_t            meas_reg, meas_next;

    logic             in_acc;
    logic             load;
    logic [CNT_W-1:0] len_now;
    logic             out_err;

    assign load     = pend_reg && (!out_valid_reg || m_tready);
    // hold the next byte while a decode waits, it would overwrite the store
    assign s_tready = !pend_reg || load;
    assign in_acc   = s_tvalid && s_tready;
    assign len_now  = (count_reg < COUNT_MAX) ? count_reg + 5'd1 : COUNT_MAX;

    always_comb begin
        count_next = count_reg;
        pend_next  = pend_reg;
        if (load) begin
            pend_next = 1'b0;
        end
        if (in_acc) begin
            if (s_tlast) begin
                count_next = '0;
                pend_next  = 1'b1;
            end else begin
                count_next = len_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && (count_reg < STORE_LIM)) begin
            store_reg[count_reg] <= s_tdata;
        end
        if (in_acc && s_tlast) begin
            len_reg <= len_now;
        end
    end

    function automatic logic [15:0] get_u16(input logic [7:0] hi, input logic [7:0] lo);
        return {hi, lo};
    endfunction

    logic [15:0] f3_mag;
    logic [15:0] f5_power;
    logic [6:0]  f5_tx;

    always_comb begin
        f3_mag   = 16'(store_reg[4][6:0]) * FMT3_SCALE + {7'd0, store_reg[5], 1'b0};
        f5_power = get_u16(store_reg[15], store_reg[16]);
        f5_tx    = {1'b0, f5_power[4:0], 1'b0} - TX_OFFSET;
        meas_next   = '0;
        status_next = ST_UNKNOWN_FM;
        if (len_reg < 5'd2) begin
            status_next = ST_TOO_SHORT;
        end else if (get_u16(store_reg[0], store_reg[1]) != company_id_reg) begin
            status_next = ST_WRONG_ID;
        end else if (len_reg < 5'd3) begin
            status_next = ST_UNKNOWN_FM;
        end else if (store_reg[2] == FMT3_CODE) begin
            if (len_reg != FMT3_LEN) begin
                status_next = ST_WRONG_LEN;
            end else begin
                status_next           = ST_FMT3_OK;
                meas_next.temperature = store_reg[4][7] ? (16'd0 - f3_mag) : f3_mag;
                meas_next.humidity    = 16'(store_reg[3]) * FMT3_SCALE;
                meas_next.pressure    = {1'b0, get_u16(store_reg[6], store_reg[7])}
                                        + PRESSURE_OFFSET;
                meas_next.accel_x     = get_u16(store_reg[8], store_reg[9]);
                meas_next.accel_y     = get_u16(store_reg[10], store_reg[11]);
                meas_next.accel_z     = get_u16(store_reg[12], store_reg[13]);
                meas_next.battery_mv  = get_u16(store_reg[14], store_reg[15]);
            end
        end else if (store_reg[2] == FMT5_CODE) begin
            if (len_reg != FMT5_LEN) begin
                status_next = ST_WRONG_LEN;
            end else begin
                status_next               = ST_FMT5_OK;
                meas_next.temperature     = get_u16(store_reg[3], store_reg[4]);
                meas_next.humidity        = get_u16(store_reg[5], store_reg[6]);
                meas_next.pressure        = {1'b0, get_u16(store_reg[7], store_reg[8])}
                                            + PRESSURE_OFFSET;
                meas_next.accel_x         = get_u16(store_reg[9], store_reg[10]);
                meas_next.accel_y         = get_u16(store_reg[11], store_reg[12]);
                meas_next.accel_z         = get_u16(store_reg[13], store_reg[14]);
                meas_next.battery_mv      = BATT_OFFSET + {5'd0, f5_power[15:5]};
                meas_next.tx_power_dbm    = f5_tx;
                meas_next.movement_count  = store_reg[17];
                meas_next.sequence_number = get_u16(store_reg[18], store_reg[19]);
                meas_next.mac_address     = {store_reg[20], store_reg[21], store_reg[22],
                                             store_reg[23], store_reg[24], store_reg[25]};
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            company_id_reg <= COMPANY_ID_RESET;
        end else begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                company_id_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= status_next;
            meas_reg   <= meas_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = meas_reg;
    assign m_tuser  = status_reg;

    assign out_err = (m_tuser != ST_FMT3_OK) && (m_tuser != ST_FMT5_OK);

    `STAD_ASSERT_NXT(a_last_sets_pend, aclk, aresetn, in_acc && s_tlast, pend_reg && count_reg == '0)
    `STAD_ASSERT_IMP(a_store_guard, aclk, aresetn, pend_reg && !load, !s_tready)
    `STAD_ASSERT_IMP(a_err_zero, aclk, aresetn, m_tvalid && out_err, m_tdata == '0)
    `STAD_ASSERT_NXT(a_load_valid, aclk, aresetn, load, m_tvalid)

endmodule
